// ===== hw/rtl/hclb_pkg.sv =====
// Package for the hop channel list builder.
// Holds shared constants, the sequencer state type, the scan control struct
// and the candidate function. Depends on nothing.
package hclb_pkg;

  localparam int unsigned HopSlotsDef = 16;
  localparam int unsigned ListLen     = 16;
  localparam int unsigned KeyW        = 7;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned SlotW       = 4;
  localparam logic [ChanW:0] ChanMod  = 9'd255;
  localparam logic [ChanW:0] ChanStep = 9'd2;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(ListLen - 1);

  typedef enum logic [1:0] {
    DivOne   = 2'd0,
    DivTwo   = 2'd1,
    DivThree = 2'd2,
    DivFive  = 2'd3
  } div_sel_e;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StScan,
    StWait,
    StEmit
  } state_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctrl_t;

  function automatic logic [KeyW-1:0] cand_of(input logic [KeyW-1:0] key,
                                              input div_sel_e sel);
    logic [13:0] p3;
    logic [13:0] p5;
    logic [KeyW-1:0] res;
    p3 = 14'(key) * 14'd43;
    p5 = 14'(key) * 14'd103;
    unique case (sel)
      DivOne:   res = key;
      DivTwo:   res = key >> 1;
      DivThree: res = p3[13:7];
      DivFive:  res = KeyW'(p5[13:9]);
      default:  res = key;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/hclb_mem.sv =====
// Hop table storage: one write port, one registered read port.
// Entries at or above the fill count read as zero. Uses hclb_pkg.
module hclb_mem #(
  parameter int unsigned HopSlots = hclb_pkg::HopSlotsDef,
  parameter int unsigned AddrW    = $clog2(HopSlots)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [hclb_pkg::ChanW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  input  logic [AddrW-1:0]           fill_i,
  output logic [hclb_pkg::ChanW-1:0] rdata_o
);

  logic [hclb_pkg::ChanW-1:0] mem_q [HopSlots];
  logic [hclb_pkg::ChanW-1:0] rdata_q;
  logic                       empty_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    empty_q <= (raddr_i >= fill_i);
  end

  assign rdata_o = empty_q ? '0 : rdata_q;

endmodule

// ===== hw/rtl/hclb_scan_unit.sv =====
// Shared compare unit: tracks the largest table entry and whether the
// candidate is present, then forms the channel. Uses hclb_pkg.
module hclb_scan_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hclb_pkg::scan_ctrl_t       ctrl_i,
  input  logic [hclb_pkg::KeyW-1:0]  cand_i,
  input  logic [hclb_pkg::ChanW-1:0] entry_i,
  output logic [hclb_pkg::ChanW-1:0] chan_o
);

  logic [hclb_pkg::ChanW-1:0] max_q, max_d;
  logic                       seen_q, seen_d;
  logic [hclb_pkg::ChanW:0]   sum;
  logic [hclb_pkg::ChanW:0]   wrapped;

  always_comb begin
    max_d  = max_q;
    seen_d = seen_q;
    if (ctrl_i.clr) begin
      max_d  = '0;
      seen_d = 1'b0;
    end else if (ctrl_i.vld) begin
      if (entry_i > max_q) begin
        max_d = entry_i;
      end
      if (entry_i == hclb_pkg::ChanW'(cand_i)) begin
        seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      max_q  <= max_d;
      seen_q <= seen_d;
    end
  end

  assign sum     = {1'b0, max_q} + hclb_pkg::ChanStep;
  assign wrapped = (sum >= hclb_pkg::ChanMod) ? (sum - hclb_pkg::ChanMod) : sum;
  assign chan_o  = seen_q ? wrapped[hclb_pkg::ChanW-1:0] : hclb_pkg::ChanW'(cand_i);

endmodule

// ===== hw/rtl/hop_channel_list_builder.sv =====
// Top level of the hop channel list builder: sequencer, key registers, outputs.
// Depends on hclb_pkg, hclb_mem and hclb_scan_unit.
//
// One item (a four-byte bind header) yields sixteen channel results, one per
// strobe on valid_o, each present for a single cycle; the receiver cannot
// stall. Each channel is built in order: the candidate is loaded, then the
// single comparator reads one table entry per cycle across all HOP_SLOTS
// entries, the registered read is drained, and the channel is stored and
// emitted. busy is high while an item is being built. No clearing pass is
// needed after reset.
module hop_channel_list_builder #(
  parameter int unsigned HOP_SLOTS = hclb_pkg::HopSlotsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [7:0]                  key_byte0_i,
  input  logic [7:0]                  key_byte1_i,
  input  logic [7:0]                  key_byte2_i,
  input  logic [7:0]                  key_byte3_i,
  output logic                        valid_o,
  output logic [hclb_pkg::SlotW-1:0]  slot_index_o,
  output logic [hclb_pkg::ChanW-1:0]  hop_channel_o,
  output logic                        last_slot_o
);

  localparam int unsigned AddrW = $clog2(HOP_SLOTS);

  hclb_pkg::state_e state_q, state_d;

  logic [hclb_pkg::KeyW-1:0]  key_q [4];
  logic [hclb_pkg::KeyW-1:0]  cand_q;
  logic [AddrW-1:0]           addr_q, addr_d;
  logic [hclb_pkg::SlotW-1:0] slot_q, slot_d;
  logic                       rd_vld_q;
  logic                       accept;
  logic                       scan_end;
  logic                       list_end;

  logic                       mem_we;
  logic [hclb_pkg::ChanW-1:0] entry;
  logic [hclb_pkg::ChanW-1:0] chan;
  hclb_pkg::scan_ctrl_t       scan_ctrl;

  logic                       valid_q;
  logic [hclb_pkg::SlotW-1:0] out_slot_q;
  logic [hclb_pkg::ChanW-1:0] out_chan_q;
  logic                       out_last_q;

  assign accept   = start && !busy;
  assign scan_end = (addr_q == AddrW'(HOP_SLOTS - 1));
  assign list_end = (slot_q == hclb_pkg::LastSlot);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hclb_pkg::StIdle: if (start) state_d = hclb_pkg::StPrep;
      hclb_pkg::StPrep: state_d = hclb_pkg::StScan;
      hclb_pkg::StScan: if (scan_end) state_d = hclb_pkg::StWait;
      hclb_pkg::StWait: state_d = hclb_pkg::StEmit;
      hclb_pkg::StEmit: state_d = list_end ? hclb_pkg::StIdle : hclb_pkg::StPrep;
      default:          state_d = hclb_pkg::StIdle;
    endcase
  end

  always_comb begin
    busy          = (state_q != hclb_pkg::StIdle);
    scan_ctrl.clr = (state_q == hclb_pkg::StPrep);
    scan_ctrl.vld = rd_vld_q;
    mem_we        = (state_q == hclb_pkg::StEmit);
    addr_d        = addr_q;
    slot_d        = slot_q;
    unique case (state_q)
      hclb_pkg::StIdle: slot_d = '0;
      hclb_pkg::StPrep: addr_d = '0;
      hclb_pkg::StScan: addr_d = addr_q + AddrW'(1);
      hclb_pkg::StWait: addr_d = addr_q;
      hclb_pkg::StEmit: slot_d = slot_q + hclb_pkg::SlotW'(1);
      default:          addr_d = addr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hclb_pkg::StIdle;
      addr_q   <= '0;
      slot_q   <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      slot_q   <= slot_d;
      rd_vld_q <= (state_q == hclb_pkg::StScan);
      valid_q  <= (state_q == hclb_pkg::StEmit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q[0] <= key_byte0_i[hclb_pkg::KeyW-1:0];
      key_q[1] <= key_byte1_i[hclb_pkg::KeyW-1:0];
      key_q[2] <= key_byte2_i[hclb_pkg::KeyW-1:0];
      key_q[3] <= key_byte3_i[hclb_pkg::KeyW-1:0];
    end
    if (state_q == hclb_pkg::StPrep) begin
      cand_q <= hclb_pkg::cand_of(key_q[slot_q[1:0]],
                                  hclb_pkg::div_sel_e'(slot_q[3:2]));
    end
    if (state_q == hclb_pkg::StEmit) begin
      out_slot_q <= slot_q;
      out_chan_q <= chan;
      out_last_q <= list_end;
    end
  end

  hclb_mem #(
    .HopSlots (HOP_SLOTS),
    .AddrW    (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(slot_q)),
    .wdata_i (chan),
    .raddr_i (addr_q),
    .fill_i  (AddrW'(slot_q)),
    .rdata_o (entry)
  );

  hclb_scan_unit u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .cand_i  (cand_q),
    .entry_i (entry),
    .chan_o  (chan)
  );

  assign valid_o       = valid_q;
  assign slot_index_o  = out_slot_q;
  assign hop_channel_o = out_chan_q;
  assign last_slot_o   = out_last_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for two cycles");

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_slot_o) |-> (slot_index_o == hclb_pkg::LastSlot))
    else $error("last flag on wrong slot");

  a_busy_mid_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_slot_o) |-> busy)
    else $error("idle before list complete");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hop_channel_o != 8'd255))
    else $error("channel out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && slot_q == '0))
    else $error("item accepted without starting list");

endmodule

// ===== verif/hop_channel_list_builder_tb.sv =====
// Testbench for hop_channel_list_builder: drives bind headers, predicts each
// sixteen-entry hop list and checks every channel strobe against it.
// Depends on hclb_pkg and the hop_channel_list_builder RTL.
`timescale 1ns / 1ps

module hop_channel_list_builder_tb;

  localparam int unsigned HopSlots = hclb_pkg::HopSlotsDef;
  localparam int unsigned RandItems = 131;

  typedef struct packed {
    logic [hclb_pkg::SlotW-1:0] slot;
    logic [hclb_pkg::ChanW-1:0] chan;
    logic                       last;
  } hop_entry_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [7:0]                 key_byte0_i;
  logic [7:0]                 key_byte1_i;
  logic [7:0]                 key_byte2_i;
  logic [7:0]                 key_byte3_i;
  logic                       valid_o;
  logic [hclb_pkg::SlotW-1:0] slot_index_o;
  logic [hclb_pkg::ChanW-1:0] hop_channel_o;
  logic                       last_slot_o;

  hop_entry_t expected_hops[$];
  int unsigned mismatch_cnt;

  hop_channel_list_builder #(
    .HOP_SLOTS(HopSlots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .key_byte0_i  (key_byte0_i),
    .key_byte1_i  (key_byte1_i),
    .key_byte2_i  (key_byte2_i),
    .key_byte3_i  (key_byte3_i),
    .valid_o      (valid_o),
    .slot_index_o (slot_index_o),
    .hop_channel_o(hop_channel_o),
    .last_slot_o  (last_slot_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void predict_hop_list(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3);
    logic [6:0] keys [4];
    logic [7:0] chan_tab [HopSlots];
    int unsigned divisor;
    int unsigned cand;
    int unsigned top;
    int unsigned chan;
    logic hit;
    hclb_pkg::div_sel_e sel;
    hop_entry_t entry;
    keys[0] = b0[6:0];
    keys[1] = b1[6:0];
    keys[2] = b2[6:0];
    keys[3] = b3[6:0];
    for (int i = 0; i < HopSlots; i++) begin
      chan_tab[i] = '0;
    end
    for (int k = 0; k < hclb_pkg::ListLen; k++) begin
      sel = hclb_pkg::div_sel_e'(k >> 2);
      case (sel)
        hclb_pkg::DivOne:   divisor = 1;
        hclb_pkg::DivTwo:   divisor = 2;
        hclb_pkg::DivThree: divisor = 3;
        default:            divisor = 5;
      endcase
      cand = int'(keys[k % 4]) / divisor;
      top = 0;
      hit = 1'b0;
      for (int i = 0; i < HopSlots; i++) begin
        if (chan_tab[i] > top) begin
          top = chan_tab[i];
        end
        if (chan_tab[i] == cand) begin
          hit = 1'b1;
        end
      end
      chan = hit ? (top + 2) % 255 : cand;
      chan_tab[k] = chan[7:0];
      entry.slot = k[hclb_pkg::SlotW-1:0];
      entry.chan = chan[hclb_pkg::ChanW-1:0];
      entry.last = (k == hclb_pkg::ListLen - 1);
      expected_hops.push_back(entry);
    end
  endfunction

  always @(posedge clk_i) begin
    hop_entry_t want;
    if (valid_o === 1'b1) begin
      if (expected_hops.size() == 0) begin
        $error("unexpected channel: slot %0d chan %0d", slot_index_o, hop_channel_o);
        mismatch_cnt++;
      end else begin
        want = expected_hops.pop_front();
        if (slot_index_o !== want.slot) begin
          $error("slot_index: expected %0d, actual %0d", want.slot, slot_index_o);
          mismatch_cnt++;
        end
        if (hop_channel_o !== want.chan) begin
          $error("hop_channel: expected %0d, actual %0d", want.chan, hop_channel_o);
          mismatch_cnt++;
        end
        if (last_slot_o !== want.last) begin
          $error("last_slot: expected %0d, actual %0d", want.last, last_slot_o);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic send_header(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_byte0_i <= b0;
    key_byte1_i <= b1;
    key_byte2_i <= b2;
    key_byte3_i <= b3;
    start       <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    predict_hop_list(b0, b1, b2, b3);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (expected_hops.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned rand_gap();
    return $urandom_range(0, 10);
  endfunction

  task automatic test_extremes();
    send_header(8'h00, 8'h00, 8'h00, 8'h00, rand_gap());
    send_header(8'hFF, 8'hFF, 8'hFF, 8'hFF, rand_gap());
    send_header(8'h7F, 8'h7F, 8'h7F, 8'h7F, rand_gap());
    send_header(8'h80, 8'h80, 8'h80, 8'h80, rand_gap());
    send_header(8'h00, 8'hFF, 8'h7F, 8'h80, rand_gap());
    send_header(8'hAA, 8'h55, 8'hAA, 8'h55, rand_gap());
    send_header(8'h01, 8'hFE, 8'h81, 8'h7E, rand_gap());
  endtask

  task automatic test_collisions();
    send_header(8'h01, 8'h01, 8'h01, 8'h01, rand_gap());
    send_header(8'h03, 8'h03, 8'h03, 8'h03, rand_gap());
    send_header(8'h0F, 8'h0F, 8'h0F, 8'h0F, rand_gap());
    send_header(8'h05, 8'h0A, 8'h0F, 8'h14, rand_gap());
    send_header(8'h02, 8'h04, 8'h06, 8'h86, rand_gap());
    send_header(8'h7E, 8'h7F, 8'hFE, 8'hFF, rand_gap());
  endtask

  task automatic test_back_to_back();
    send_header(8'h12, 8'h34, 8'h56, 8'h78, 0);
    send_header(8'h9A, 8'hBC, 8'hDE, 8'hF0, 0);
    send_header(8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_header(8'hFF, 8'h00, 8'hFF, 8'h00, 0);
  endtask

  task automatic test_drain_pause();
    send_header(8'h3C, 8'hC3, 8'h5A, 8'hA5, rand_gap());
    hold_until_drained();
    send_header(8'h64, 8'h19, 8'h0C, 8'h06, 0);
    hold_until_drained();
  endtask

  task automatic test_random();
    logic [7:0] hdr [4];
    logic [7:0] seed_byte;
    int unsigned mode;
    bit burst;
    burst = 1'b0;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 20 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      mode = $urandom_range(0, 9);
      seed_byte = 8'($urandom());
      for (int j = 0; j < 4; j++) begin
        if (mode < 6) begin
          hdr[j] = 8'($urandom());
        end else if (mode < 8) begin
          hdr[j] = seed_byte ^ {1'($urandom_range(0, 1)), 7'd0};
        end else begin
          hdr[j] = {1'($urandom_range(0, 1)), 3'd0, 4'($urandom_range(0, 15))};
        end
      end
      send_header(hdr[0], hdr[1], hdr[2], hdr[3], burst ? 0 : rand_gap());
      if (n == RandItems / 2) begin
        hold_until_drained();
      end
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    key_byte0_i <= '0;
    key_byte1_i <= '0;
    key_byte2_i <= '0;
    key_byte3_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_collisions();
    test_back_to_back();
    test_drain_pause();
    test_random();

    hold_until_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_hops.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
